// ===== rtl/core/pdr_pkg.sv =====
// Shared types and constants of the packet deframer and responder.
// No dependencies; the framer, queue, responder and top level import this package.
package pdr_pkg;

    // Command codes and fixed packet bytes.
    localparam logic [7:0]  CMD_STARTUP     = 8'h04;
    localparam logic [7:0]  CMD_VERSION     = 8'h09;
    localparam logic [7:0]  CMD_TOWER       = 8'h0B;
    localparam int          ACK_BIT         = 7;
    localparam logic [7:0]  VERSION_TAG     = 8'h76;
    localparam logic [7:0]  TOWER_SET       = 8'h02;
    localparam logic [7:0]  TOWER_REPORT    = 8'h01;
    localparam logic [15:0] TOWER_RESET     = 16'h241A;

    // Configuration registers.
    localparam int          CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAJOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 1'b1;
    localparam logic [7:0]  VERSION_MAJOR_RESET = 8'h01;
    localparam logic [7:0]  VERSION_MINOR_RESET = 8'h00;

    // Depth of the queue between framer and responder.
    localparam int          QUEUE_DEPTH     = 4;

    // Reply classes a received packet calls for.
    typedef struct packed {
        logic startup;
        logic version;
        logic tower;
        logic ack;
    } t_cls;

    // One accepted packet, classified, as it travels to the responder.
    typedef struct packed {
        t_cls       cls;
        logic [7:0] cmd;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
    } t_pkt;

endpackage

// ===== rtl/core/pdr_in_if.sv =====
// Receive byte channel of the packet deframer and responder.
// Depends on nothing but the valid/ready handshake convention.
interface pdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/pdr_out_if.sv =====
// Reply packet channel of the packet deframer and responder.
// Depends on nothing but the valid/ready handshake convention.
interface pdr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_command;
    logic [7:0] out_param1;
    logic [7:0] out_param2;
    logic [7:0] out_param3;
    logic [7:0] out_checksum;
    logic       last_of_run;

    modport source (output valid, output out_command, output out_param1,
                    output out_param2, output out_param3, output out_checksum,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_command, input out_param1,
                    input out_param2, input out_param3, input out_checksum,
                    input last_of_run, output ready);
endinterface

// ===== rtl/core/pdr_front.sv =====
// Framer: gathers received bytes into a packet window, tests the checksum
// and classifies each valid packet. Depends on pdr_pkg and pdr_in_if.
module pdr_front
    import pdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdr_in_if.sink      i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_pkt        o_pkt
);

    logic [7:0] r_win [4];
    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic       accept;
    logic       filling;
    logic       match;
    logic [6:0] base;
    t_cls       cls;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign filling    = !r_pos[2];
    assign match      = (r_win[0] ^ r_win[1] ^ r_win[2] ^ r_win[3]) == i_in.rx_byte;
    assign base       = r_win[0][6:0];

    always_comb begin
        cls.startup = (base == CMD_STARTUP[6:0]);
        cls.version = (base == CMD_VERSION[6:0]);
        cls.tower   = (base == CMD_TOWER[6:0]);
        cls.ack     = r_win[0][ACK_BIT];
    end

    always_comb begin
        o_pkt.cls = cls;
        o_pkt.cmd = r_win[0];
        o_pkt.p1  = r_win[1];
        o_pkt.p2  = r_win[2];
        o_pkt.p3  = r_win[3];
    end

    // A packet that asks for no reply is dropped here.
    assign o_push = accept && !filling && match && (cls != '0);

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (filling) begin
                n_pos = r_pos + 3'd1;
            end else if (match) begin
                n_pos = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // On a checksum mismatch the window slides and the byte becomes param3.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (filling) begin
                r_win[r_pos[1:0]] <= i_in.rx_byte;
            end else if (!match) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_win[3];
                r_win[3] <= i_in.rx_byte;
            end
        end
    end

endmodule

// ===== rtl/core/pdr_queue.sv =====
// Small FIFO of classified packets between framer and responder.
// Depends on pdr_pkg for the entry type.
module pdr_queue
    import pdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_pkt o_pkt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_pkt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_pkt   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("packet pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("packet popped from an empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue fill count out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("queue fill count did not follow a push");

endmodule

// ===== rtl/core/pdr_back.sv =====
// Responder: takes classified packets from the queue, produces their reply
// packets one at a time into an output register and owns the tower number.
// Depends on pdr_pkg and pdr_out_if.
module pdr_back
    import pdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_pkt       i_q_pkt,
    output logic       o_pop,
    input  logic [7:0] i_version_major,
    input  logic [7:0] i_version_minor,
    pdr_out_if.source  o_out
);

    // Pending replies, in the order they go out:
    // [0] startup reply, [1] version, [2] tower report, [3] tower command, [4] ack echo.
    logic [4:0]  r_pend;
    logic [4:0]  n_pend;
    logic [4:0]  low;
    logic [4:0]  rem;
    t_pkt        r_cur;
    logic [15:0] r_tower;
    logic        r_o_valid;
    logic [7:0]  r_cmd;
    logic [7:0]  r_p1;
    logic [7:0]  r_p2;
    logic [7:0]  r_p3;
    logic [7:0]  r_sum;
    logic        r_last;
    logic        out_free;
    logic        emit;
    logic [7:0]  s_cmd;
    logic [7:0]  s_p1;
    logic [7:0]  s_p2;
    logic [7:0]  s_p3;

    assign out_free = !r_o_valid || o_out.ready;
    assign emit     = out_free && (r_pend != '0);
    assign low      = r_pend & (~r_pend + 5'd1);
    assign rem      = r_pend & ~low;
    assign o_pop    = i_q_valid && ((r_pend == '0) || (emit && (rem == '0)));

    always_comb begin
        priority if (r_pend[0]) begin
            s_cmd = CMD_STARTUP;
            s_p1  = 8'h00;
            s_p2  = 8'h00;
            s_p3  = 8'h00;
        end else if (r_pend[1]) begin
            s_cmd = CMD_VERSION;
            s_p1  = VERSION_TAG;
            s_p2  = i_version_major;
            s_p3  = i_version_minor;
        end else if (r_pend[2]) begin
            s_cmd = CMD_TOWER;
            s_p1  = TOWER_REPORT;
            s_p2  = r_tower[15:8];
            s_p3  = r_tower[7:0];
        end else if (r_pend[3]) begin
            s_cmd = CMD_TOWER;
            s_p1  = r_cur.p1;
            s_p2  = (r_cur.p1 == TOWER_SET) ? r_cur.p2 : r_tower[15:8];
            s_p3  = (r_cur.p1 == TOWER_SET) ? r_cur.p3 : r_tower[7:0];
        end else begin
            s_cmd = r_cur.cmd;
            s_p1  = r_cur.p1;
            s_p2  = r_cur.p2;
            s_p3  = r_cur.p3;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (emit) begin
            n_pend = rem;
        end
        if (o_pop) begin
            n_pend = {i_q_pkt.cls.ack, i_q_pkt.cls.tower, i_q_pkt.cls.startup,
                      i_q_pkt.cls.startup | i_q_pkt.cls.version, i_q_pkt.cls.startup};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_o_valid <= 1'b0;
            r_tower   <= TOWER_RESET;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (emit && low[3] && (r_cur.p1 == TOWER_SET)) begin
                r_tower <= {r_cur.p2, r_cur.p3};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_pkt;
        end
        if (emit) begin
            r_cmd  <= s_cmd;
            r_p1   <= s_p1;
            r_p2   <= s_p2;
            r_p3   <= s_p3;
            r_sum  <= s_cmd ^ s_p1 ^ s_p2 ^ s_p3;
            r_last <= (rem == '0);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.out_command  = r_cmd;
    assign o_out.out_param1   = r_p1;
    assign o_out.out_param2   = r_p2;
    assign o_out.out_param3   = r_p3;
    assign o_out.out_checksum = r_sum;
    assign o_out.last_of_run  = r_last;

endmodule

// ===== rtl/core/packet_deframer_responder_core.sv =====
// Top level of the packet deframer and responder: framer, packet queue,
// responder and the version registers. Depends on pdr_pkg and all rtl/core modules.
//
// Received bytes are taken one per cycle while the packet queue has room. Once
// four bytes are held, a byte that matches the XOR of those four completes a
// packet; otherwise the window slides by one byte. A valid packet that calls
// for a reply is queued and the responder sends its replies (up to four:
// startup gives three, the ack bit adds an echo) one per cycle while the output
// is ready, through a registered output, each with its own XOR checksum and
// last_of_run set on the final one. The output port sets the sustained rate and
// the queue of DEPTH packets absorbs bursts. The user must write the version
// registers via the plain write port only when idle; the block does not enforce it.
module packet_deframer_responder_core
    import pdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pdr_in_if.sink               i_in,
    pdr_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_version_major;
    logic [7:0] r_version_minor;
    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_pkt       push_pkt;
    t_pkt       q_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version_major <= VERSION_MAJOR_RESET;
            r_version_minor <= VERSION_MINOR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_VERSION_MAJOR) begin
                r_version_major <= i_cfg_data;
            end else if (i_cfg_idx == CFG_VERSION_MINOR) begin
                r_version_minor <= i_cfg_data;
            end
        end
    end

    pdr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_pkt    (push_pkt)
    );

    pdr_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_pkt   (q_pkt)
    );

    pdr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_pkt         (q_pkt),
        .o_pop           (pop),
        .i_version_major (r_version_major),
        .i_version_minor (r_version_minor),
        .o_out           (o_out)
    );

endmodule
